FILE: rtl/sce_pkg.sv
// Shared types and constants for the strip cluster eta block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none
package sce_pkg;
  localparam int CountW = 14;
  localparam int NoiseW = 16;
  localparam int SumW = 16;
  localparam int QW = 18;
  localparam int QuoW = 34;       // |num*65536| < 2^33, signed
  localparam int SqW = 34;        // sum of three 16-bit squares
  localparam int RootW = 17;
  localparam logic signed [QW-1:0] QMax = 18'sd131071;
  localparam logic signed [QW-1:0] QMin = -18'sd131072;

  localparam logic [1:0] AddrThreshold = 2'd0;
  localparam logic [1:0] AddrMode = 2'd1;

  // Front-end results that travel with each beat into the divide/root stages.
  typedef struct packed {
    logic signed [SumW-1:0] eta_num;
    logic signed [SumW-1:0] eta_den;
    logic [SqW-1:0] sq;
    logic [1:0] total;
    logic signed [SumW-1:0] csum;
    logic signed [SumW-1:0] cw;
    logic signed [14:0] sides;
    logic start_b;
    logic stop_b;
  } front_t;
endpackage
`default_nettype wire

FILE: rtl/sce_front.sv
// Front end: border flags, threshold tests, neighbor choice and sums.
// Two register stages. Depends on sce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sce_front #(
  parameter int LADDER_STRIPS = 384
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [11:0] seed_position,
  input  wire logic signed [13:0] left_count,
  input  wire logic signed [13:0] seed_count,
  input  wire logic signed [13:0] right_count,
  input  wire logic [15:0] left_noise,
  input  wire logic [15:0] seed_noise,
  input  wire logic [15:0] right_noise,
  input  wire logic [15:0] side_threshold,
  input  wire logic eta_mode,
  output logic out_valid,
  output sce_pkg::front_t out_data
);
  localparam logic [11:0] LastStrip = 12'(LADDER_STRIPS - 1);

  // stage 1: products
  logic v1;
  logic signed [13:0] c1 [3];
  logic [15:0] n1 [3];
  logic st1, sp1, mode1;
  logic ab1 [3];
  logic cmp1;
  logic [31:0] nsq1 [3];

  logic start_c, stop_c;
  logic signed [13:0] cc [3];
  logic [15:0] nc [3];
  logic ok_c [3];
  logic [31:0] thr_p [3];
  logic signed [30:0] xl, xr;
  assign start_c = (seed_position == 12'd0);
  assign stop_c = (seed_position >= LastStrip);
  always_comb begin
    cc[0] = start_c ? 14'sd0 : left_count;
    cc[1] = seed_count;
    cc[2] = stop_c ? 14'sd0 : right_count;
    nc[0] = start_c ? 16'd0 : left_noise;
    nc[1] = seed_noise;
    nc[2] = stop_c ? 16'd0 : right_noise;
    ok_c[0] = !start_c;
    ok_c[1] = 1'b1;
    ok_c[2] = !stop_c;
    // full 32-bit threshold products
    for (int i = 0; i < 3; i++) thr_p[i] = side_threshold * nc[i];
    // cross products for the neighbor choice
    xl = cc[0] * $signed({1'b0, nc[2]});
    xr = cc[2] * $signed({1'b0, nc[0]});
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    st1 <= start_c;
    sp1 <= stop_c;
    mode1 <= eta_mode;
    for (int i = 0; i < 3; i++) begin
      c1[i] <= cc[i];
      n1[i] <= nc[i];
      nsq1[i] <= nc[i] * nc[i];
      ab1[i] <= ok_c[i] && ($signed({cc[i], 16'd0}) > $signed({1'b0, thr_p[i]}));
    end
    cmp1 <= (xl > xr);
  end

  // stage 2: choice and sums
  logic use_left;
  sce_pkg::front_t f;
  always_comb begin
    use_left = !st1 && (sp1 || cmp1);
    f.start_b = st1;
    f.stop_b = sp1;
    if (mode1) begin
      f.eta_num = 16'(c1[1]) + 16'(c1[2]) + 16'(c1[2]);
      f.eta_den = 16'(c1[0]) + 16'(c1[1]) + 16'(c1[2]);
      f.sq = 34'(nsq1[0]) + 34'(nsq1[1]) + 34'(nsq1[2]);
    end else begin
      f.eta_num = use_left ? 16'(c1[1]) : 16'(c1[2]);
      f.eta_den = 16'(c1[1]) + (use_left ? 16'(c1[0]) : 16'(c1[2]));
      f.sq = 34'(nsq1[1]) + 34'(use_left ? nsq1[0] : nsq1[2]);
    end
    f.total = 2'(ab1[0]) + 2'(ab1[1]) + 2'(ab1[2]);
    f.csum = (ab1[0] ? 16'(c1[0]) : 16'sd0) + (ab1[1] ? 16'(c1[1]) : 16'sd0)
           + (ab1[2] ? 16'(c1[2]) : 16'sd0);
    f.cw = (ab1[1] ? 16'(c1[1]) : 16'sd0) + (ab1[2] ? 16'(c1[2]) + 16'(c1[2]) : 16'sd0);
    f.sides = (ab1[0] ? 15'(c1[0]) : 15'sd0) + (ab1[2] ? 15'(c1[2]) : 15'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    out_data <= f;
  end
endmodule
`default_nettype wire

FILE: rtl/sce_div.sv
// Pipelined signed Q2.16 divider, one quotient bit per restoring stage, saturating.
// Depends on sce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sce_div #(
  parameter int TAG_W = 8
) (
  input  wire logic clk,
  input  wire logic [TAG_W-1:0] tag_in,
  input  wire logic signed [15:0] num,
  input  wire logic signed [15:0] den,
  output logic [TAG_W-1:0] tag_out,
  output logic signed [17:0] quo,
  output logic zero
);
  localparam int NB = 32;   // dividend magnitude bits (|num|*65536 < 2^32)
  localparam int S = NB + 2;

  logic [TAG_W-1:0] tg [S];
  logic [NB-1:0] rem_q [S];     // shifting dividend / quotient
  logic [16:0] part [S];        // partial remainder
  logic [15:0] dv [S];
  logic neg [S];
  logic zr [S];

  logic [15:0] an, ad;
  assign an = num[15] ? 16'(-num) : 16'(num);
  assign ad = den[15] ? 16'(-den) : 16'(den);

  always_ff @(posedge clk) begin
    tg[0] <= tag_in;
    rem_q[0] <= {an, 16'd0};
    part[0] <= 17'd0;
    dv[0] <= ad;
    neg[0] <= num[15] ^ den[15];
    zr[0] <= (den == 16'sd0);
  end

  // one restoring step per stage
  for (genvar k = 1; k <= NB; k++) begin : g_step
    logic [17:0] trial;
    logic [17:0] diff;
    assign trial = {part[k-1], rem_q[k-1][NB-1]};
    assign diff = trial - {2'd0, dv[k-1]};
    always_ff @(posedge clk) begin
      tg[k] <= tg[k-1];
      dv[k] <= dv[k-1];
      neg[k] <= neg[k-1];
      zr[k] <= zr[k-1];
      if (!diff[17]) begin
        part[k] <= diff[16:0];
        rem_q[k] <= {rem_q[k-1][NB-2:0], 1'b1};
      end else begin
        part[k] <= trial[16:0];
        rem_q[k] <= {rem_q[k-1][NB-2:0], 1'b0};
      end
    end
  end

  // sign and saturate
  logic signed [33:0] sq;
  logic signed [17:0] sat;
  always_comb begin
    sq = neg[NB] ? -$signed({2'b0, rem_q[NB]}) : $signed({2'b0, rem_q[NB]});
    if (sq > 34'(sce_pkg::QMax)) sat = sce_pkg::QMax;
    else if (sq < 34'(sce_pkg::QMin)) sat = sce_pkg::QMin;
    else sat = sq[17:0];
  end
  always_ff @(posedge clk) begin
    tg[S-1] <= tg[NB];
    part[S-1] <= part[NB];
    rem_q[S-1] <= rem_q[NB];
    dv[S-1] <= dv[NB];
    neg[S-1] <= neg[NB];
    zr[S-1] <= zr[NB];
    quo <= zr[NB] ? 18'sd0 : sat;
  end
  assign tag_out = tg[S-1];
  assign zero = zr[S-1];
endmodule
`default_nettype wire

FILE: rtl/sce_sqrt.sv
// Pipelined integer square root, one result bit per step stage, giving a 17-bit root.
// Depends on sce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sce_sqrt (
  input  wire logic clk,
  input  wire logic [sce_pkg::SqW-1:0] val,
  output logic [sce_pkg::RootW-1:0] root
);
  localparam int N = 17;          // root bits for a 34-bit radicand
  logic [33:0] rad [N+1];
  logic [16:0] r [N+1];
  logic [35:0] rm [N+1];

  always_ff @(posedge clk) begin
    rad[0] <= val;
    r[0] <= 17'd0;
    rm[0] <= 36'd0;
  end

  // digit-by-digit: bring down two bits, try 4r+1
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [35:0] cur;
    logic [35:0] tr;
    assign cur = {rm[k-1][33:0], rad[k-1][33:32]};
    assign tr = {17'd0, r[k-1], 2'b01};
    always_ff @(posedge clk) begin
      rad[k] <= {rad[k-1][31:0], 2'b00};
      if (cur >= tr) begin
        rm[k] <= cur - tr;
        r[k] <= {r[k-1][15:0], 1'b1};
      end else begin
        rm[k] <= cur;
        r[k] <= {r[k-1][15:0], 1'b0};
      end
    end
  end
  assign root = r[N];
endmodule
`default_nettype wire

FILE: rtl/strip_cluster_eta.sv
// Top level of the strip cluster eta block: config registers and pipeline.
// Depends on sce_pkg, sce_front, sce_div, sce_sqrt.
`timescale 1ns / 1ps
`default_nettype none
// A cluster beat is taken on any cycle with start high (busy is always low), so
// one beat per clock is sustained. Its result appears with done high after two
// front-end stages (the first loads at the accepting edge), then the two 34-stage
// restoring dividers for eta and charge centre (one quotient bit per restoring
// step), plus an output register; the square root and its delay line run
// alongside. The receiver cannot stall.
module strip_cluster_eta #(
  parameter int LADDER_STRIPS = 384
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic start,
  output logic busy,
  input  wire logic [11:0] seed_position,
  input  wire logic signed [13:0] left_count,
  input  wire logic signed [13:0] seed_count,
  input  wire logic signed [13:0] right_count,
  input  wire logic [15:0] left_noise,
  input  wire logic [15:0] seed_noise,
  input  wire logic [15:0] right_noise,
  output logic done,
  output logic signed [17:0] eta_value,
  output logic signed [15:0] eta_sum,
  output logic [16:0] eta_noise,
  output logic [1:0] strip_total,
  output logic signed [15:0] above_sum,
  output logic signed [14:0] side_sum,
  output logic signed [17:0] charge_centre,
  output logic start_border,
  output logic stop_border,
  output logic eta_invalid,
  output logic centre_invalid
);
  localparam int DivLat = 34;
  localparam int SqLat = 18;
  localparam int TagW = 2 + 16 + 15 + 2 + 1;

  logic [15:0] side_threshold;
  logic eta_mode;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      side_threshold <= 16'd768;
      eta_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        sce_pkg::AddrThreshold[0]: side_threshold <= pwdata[15:0];
        sce_pkg::AddrMode[0]: eta_mode <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[2])
      sce_pkg::AddrThreshold[0]: prdata = {16'd0, side_threshold};
      sce_pkg::AddrMode[0]: prdata = {31'd0, eta_mode};
      default: prdata = 32'd0;
    endcase
  end

  assign busy = 1'b0;

  // front end
  logic fv;
  sce_pkg::front_t fd;
  sce_front #(.LADDER_STRIPS(LADDER_STRIPS)) u_front (
    .clk, .rst, .in_valid(start && !busy), .seed_position, .left_count,
    .seed_count, .right_count, .left_noise, .seed_noise, .right_noise,
    .side_threshold, .eta_mode, .out_valid(fv), .out_data(fd)
  );

  // dividers; the eta one carries the side fields and the valid bit
  logic [TagW-1:0] tag_e;
  logic [15:0] tag_c;
  logic signed [17:0] q_eta, q_cen;
  logic z_eta, z_cen;
  sce_div #(.TAG_W(TagW)) u_div_eta (
    .clk, .tag_in({fv, fd.total, fd.csum, fd.sides, fd.start_b, fd.stop_b}),
    .num(fd.eta_num), .den(fd.eta_den), .tag_out(tag_e), .quo(q_eta), .zero(z_eta)
  );
  sce_div #(.TAG_W(16)) u_div_cen (
    .clk, .tag_in(fd.eta_den), .num(fd.cw), .den(fd.csum),
    .tag_out(tag_c), .quo(q_cen), .zero(z_cen)
  );

  // root, then delay to match the divider
  logic [16:0] root;
  logic [16:0] rdly [DivLat-SqLat];
  sce_sqrt u_sqrt (.clk, .val(fd.sq), .root(root));
  always_ff @(posedge clk) begin
    rdly[0] <= root;
    for (int i = 1; i < DivLat - SqLat; i++) rdly[i] <= rdly[i-1];
  end

  // valid bit is reset separately so no garbage beat emerges
  logic [DivLat-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else vpipe <= {vpipe[DivLat-2:0], fv};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vpipe[DivLat-1] && tag_e[TagW-1];
    eta_value <= q_eta;
    eta_invalid <= z_eta;
    eta_sum <= tag_c;
    eta_noise <= rdly[DivLat-SqLat-1];
    strip_total <= tag_e[TagW-2 -: 2];
    above_sum <= tag_e[TagW-4 -: 16];
    side_sum <= tag_e[TagW-20 -: 15];
    start_border <= tag_e[1];
    stop_border <= tag_e[0];
    charge_centre <= q_cen;
    centre_invalid <= z_cen;
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(fv, DivLat + 1))
    else $error("result without a matching front-end beat");
  assert property (@(posedge clk) disable iff (rst) done && eta_invalid |-> eta_value == 18'sd0)
    else $error("eta not forced to zero");
  assert property (@(posedge clk) disable iff (rst)
    done && centre_invalid |-> charge_centre == 18'sd0 && strip_total != 2'd3 ||
    done && !centre_invalid || !done)
    else $error("centre not forced to zero");
endmodule
`default_nettype wire
